// ===== src/dtrt_pkg.sv =====
package dtrt_pkg;

  localparam int NUM_REGS   = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int DUR_W      = 32;
  localparam int DRIVE_W    = 8;
  localparam int HELD_W     = 7;

  localparam logic [HELD_W-1:0] HELD_MAX    = '1;
  localparam logic [DUR_W-1:0]  TOGGLE_ONLY = '1;
  localparam logic [DRIVE_W-1:0] DRIVE_OFF  = '1;

  localparam logic [DUR_W-1:0] DURATION_RESET [NUM_REGS] = '{
    32'd1800000, 32'd45000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
    32'hFFFF_FFFF, 32'd1000000, 32'd1000000, 32'd1000000
  };

  typedef logic [DUR_W-1:0] duration_t;

  typedef struct packed {
    logic [DRIVE_W-1:0] drive;
    logic               changed;
  } result_t;

endpackage

// ===== src/dtrt_lane.sv =====
module dtrt_lane import dtrt_pkg::*; #(
  parameter int DEBOUNCE_MS = 100,
  parameter int TIME_WIDTH  = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  logic      level,
  input  duration_t duration,
  output logic      on_next
);

  localparam logic [TIME_WIDTH-1:0] ELAPSED_MAX = '1;

  logic                  relay_on;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  prev_level;
  logic [HELD_W-1:0]     held;

  logic [HELD_W-1:0]     held_inc;
  logic [TIME_WIDTH-1:0] elapsed_inc;
  logic                  press;
  logic                  on_toggled;
  logic [TIME_WIDTH-1:0] elapsed_toggled;
  logic [DUR_W-1:0]      elapsed_ext;
  logic                  expire;
  logic [TIME_WIDTH-1:0] elapsed_next;
  logic [HELD_W-1:0]     held_next;

  always_comb begin
    held_inc    = (held < HELD_MAX) ? held + 1'b1 : held;
    elapsed_inc = (relay_on && elapsed < ELAPSED_MAX) ? elapsed + 1'b1 : elapsed;

    // A press counts only when the released level had settled long enough.
    press = (level != prev_level) && !level && (held_inc > HELD_W'(DEBOUNCE_MS));
    on_toggled      = press ? !relay_on : relay_on;
    elapsed_toggled = press ? '0 : elapsed_inc;

    elapsed_ext = DUR_W'(elapsed_toggled);
    expire = on_toggled && (duration != TOGGLE_ONLY) && (elapsed_ext > duration);

    on_next      = expire ? 1'b0 : on_toggled;
    elapsed_next = expire ? '0 : elapsed_toggled;
    held_next    = (level != prev_level) ? '0 : held_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      relay_on   <= 1'b0;
      elapsed    <= '0;
      prev_level <= 1'b0;
      held       <= '0;
    end else if (accept) begin
      relay_on   <= on_next;
      elapsed    <= elapsed_next;
      prev_level <= level;
      held       <= held_next;
    end
  end

endmodule

// ===== src/dtrt_merge.sv =====
module dtrt_merge import dtrt_pkg::*; #(
  parameter int CHANNELS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CHANNELS-1:0] on_bits,
  output logic                out_valid,
  input  logic                out_ready,
  output result_t             result
);

  logic [DRIVE_W-1:0] prev_drive;
  logic               skid_valid;
  result_t            skid;
  result_t            fresh;
  logic               accept;

  assign in_ready = !skid_valid;
  assign accept   = in_valid && in_ready;

  always_comb begin
    fresh.drive = DRIVE_OFF;
    for (int i = 0; i < CHANNELS; i++) begin
      if (on_bits[i]) begin
        fresh.drive[i] = 1'b0;
      end
    end
    fresh.changed = (fresh.drive != prev_drive);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_drive <= DRIVE_OFF;
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (accept) begin
        prev_drive <= fresh.drive;
      end
      if (out_valid && !out_ready) begin
        // Output is stalled: a new item parks in the skid stage.
        if (accept) begin
          skid       <= fresh;
          skid_valid <= 1'b1;
        end
      end else if (skid_valid) begin
        result     <= skid;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (accept) begin
        result    <= fresh;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds an item while the output is empty");

  a_stall_parks: assert property (@(posedge clk) disable iff (rst)
    (accept && out_valid && !out_ready) |=> skid_valid)
    else $error("item accepted under a stalled output was not parked");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_ready) |=> (out_valid && !skid_valid))
    else $error("skid stage did not move to the output register");

endmodule

// ===== src/debounced_toggle_relay_timer_unit.sv =====
// Eight-channel debounced toggle relay timer. Each input item is one millisecond
// tick of active-low button levels, and each gives exactly one result item: the
// active-low relay drive byte and a flag that is set when it differs from the
// previous result. The unit takes one item per clock cycle while its skid
// stage is empty; every channel has its own lane that updates its hold and
// on-time counters. A result goes into the output register, or into the skid
// stage while the output stalls; this two-entry buffer takes one more item
// under a stall, then holds off input. Duration registers are written through
// the configuration port; a duration of all ones makes that relay toggle only.
module debounced_toggle_relay_timer_unit import dtrt_pkg::*; #(
  parameter int CHANNELS    = 8,
  parameter int DEBOUNCE_MS = 100,
  parameter int TIME_WIDTH  = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           button_levels,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DRIVE_W-1:0]   relay_drive,
  output logic                 drive_changed,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DUR_W-1:0]     cfg_data
);

  duration_t           duration [NUM_REGS];
  logic [CHANNELS-1:0] on_bits;
  logic                accept;
  result_t             result;

  assign accept        = in_valid && in_ready;
  assign relay_drive   = result.drive;
  assign drive_changed = result.changed;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        duration[i] <= DURATION_RESET[i];
      end
    end else if (cfg_write && cfg_index < CFG_IDX_W'(NUM_REGS)) begin
      duration[cfg_index[2:0]] <= cfg_data;
    end
  end

  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    dtrt_lane #(
      .DEBOUNCE_MS (DEBOUNCE_MS),
      .TIME_WIDTH  (TIME_WIDTH)
    ) u_lane (
      .clk      (clk),
      .rst      (rst),
      .accept   (accept),
      .level    (button_levels[g]),
      .duration (duration[g]),
      .on_next  (on_bits[g])
    );
  end

  dtrt_merge #(
    .CHANNELS (CHANNELS)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .on_bits   (on_bits),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  // An unused channel must never pull its drive bit low.
  a_unused_off: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((relay_drive >> CHANNELS) == (DRIVE_OFF >> CHANNELS)))
    else $error("drive bit of an unused channel is active");

endmodule

// ===== dv/debounced_toggle_relay_timer_unit_tb.sv =====
module debounced_toggle_relay_timer_unit_tb import dtrt_pkg::*; ();

  localparam int DEBOUNCE_MS = 100;
  localparam int CHANNELS    = 8;

  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SLOW, RX_PERIODIC} rx_mode_t;

  // Expected drive bytes, worked out tick by tick from the button levels.
  class relay_drive_scoreboard;
    duration_t           duration [NUM_REGS];
    logic                relay_on [CHANNELS];
    logic [DUR_W-1:0]    on_elapsed [CHANNELS];
    logic                last_level [CHANNELS];
    logic [HELD_W-1:0]   held_ms [CHANNELS];
    logic [DRIVE_W-1:0]  last_drive;
    result_t             expected_drives [$];
    int                  errors;

    function new();
      for (int ch = 0; ch < CHANNELS; ch++) begin
        duration[ch]   = DURATION_RESET[ch];
        relay_on[ch]   = 1'b0;
        on_elapsed[ch] = '0;
        last_level[ch] = 1'b0;
        held_ms[ch]    = '0;
      end
      last_drive = DRIVE_OFF;
      errors     = 0;
    endfunction

    function void set_duration(int idx, duration_t value);
      if (idx < NUM_REGS) duration[idx] = value;
    endfunction

    function int pending();
      return expected_drives.size();
    endfunction

    function void note_tick(logic [7:0] levels);
      logic [DRIVE_W-1:0] drive;
      logic               lvl;
      result_t            res;
      drive = DRIVE_OFF;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        lvl = levels[ch];
        if (held_ms[ch] != HELD_MAX) held_ms[ch]++;
        if (relay_on[ch] && on_elapsed[ch] != '1) on_elapsed[ch]++;
        // A press toggles only after the released level has settled.
        if (lvl != last_level[ch] && !lvl && held_ms[ch] > DEBOUNCE_MS) begin
          relay_on[ch]   = !relay_on[ch];
          on_elapsed[ch] = '0;
        end
        if (relay_on[ch] && duration[ch] != TOGGLE_ONLY &&
            on_elapsed[ch] > duration[ch]) begin
          relay_on[ch]   = 1'b0;
          on_elapsed[ch] = '0;
        end
        if (lvl != last_level[ch]) begin
          last_level[ch] = lvl;
          held_ms[ch]    = '0;
        end
        if (relay_on[ch]) drive[ch] = 1'b0;
      end
      res.drive   = drive;
      res.changed = (drive != last_drive);
      last_drive  = drive;
      expected_drives.push_back(res);
    endfunction

    function void check_drive(logic [DRIVE_W-1:0] drive, logic changed);
      result_t exp_res;
      if (expected_drives.size() == 0) begin
        $error("relay_drive: no item expected, got %h", drive);
        errors++;
        return;
      end
      exp_res = expected_drives.pop_front();
      if (exp_res.drive !== drive) begin
        $error("relay_drive: expected %h, got %h", exp_res.drive, drive);
        errors++;
      end
      if (exp_res.changed !== changed) begin
        $error("drive_changed: expected %b, got %b", exp_res.changed, changed);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [7:0]           button_levels;
  logic                 out_valid;
  logic                 out_ready;
  logic [DRIVE_W-1:0]   relay_drive;
  logic                 drive_changed;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DUR_W-1:0]     cfg_data;

  relay_drive_scoreboard sb;

  int        burst_left;
  bit        sender_no_gaps;
  bit        chan_level [CHANNELS];
  int        chan_run_left [CHANNELS];
  duration_t next_durations [NUM_REGS];
  rx_mode_t  rx_mode;
  logic [5:0] rx_phase;

  debounced_toggle_relay_timer_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .button_levels (button_levels),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .relay_drive   (relay_drive),
    .drive_changed (drive_changed),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  // The receiver picks a new stall pattern each time the 6-bit phase counter wraps.
  always @(posedge clk) begin
    rx_phase <= rx_phase + 6'd1;
    if (rx_phase == '0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_FREE:  out_ready <= 1'b1;
      RX_COIN:  out_ready <= 1'($urandom_range(0, 1));
      RX_SLOW:  out_ready <= ($urandom_range(0, 3) == 0);
      default:  out_ready <= rx_phase[2];
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_drive(relay_drive, drive_changed);
  end

  function automatic int pick_run(bit released);
    int r;
    r = $urandom_range(0, 9);
    if (released) begin
      // Mostly just around the debounce threshold, so both sides of it are hit.
      if (r < 6) return $urandom_range(98, 110);
      if (r < 8) return $urandom_range(111, 200);
      return $urandom_range(1, 97);
    end
    if (r < 7) return $urandom_range(1, 40);
    return $urandom_range(41, 140);
  endfunction

  function automatic logic [7:0] next_button_levels();
    logic [7:0] levels;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      if (chan_run_left[ch] == 0) begin
        chan_level[ch]    = !chan_level[ch];
        chan_run_left[ch] = pick_run(chan_level[ch]);
      end
      chan_run_left[ch]--;
      levels[ch] = chan_level[ch];
    end
    return levels;
  endfunction

  task automatic send_tick(input logic [7:0] levels);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!sender_no_gaps) begin
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    button_levels <= levels;
    do @(posedge clk); while (!in_ready);
    sb.note_tick(levels);
  endtask

  task automatic run_random(input int count);
    logic [7:0] levels;
    for (int n = 0; n < count; n++) begin
      levels = next_button_levels();
      if ($urandom_range(0, 29) == 0) levels = 8'($urandom);
      send_tick(levels);
    end
  endtask

  task automatic finish_phase();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic program_durations();
    for (int r = 0; r < NUM_REGS; r++) begin
      cfg_write <= 1'b1;
      cfg_index <= CFG_IDX_W'(r);
      cfg_data  <= next_durations[r];
      @(posedge clk);
      sb.set_duration(r, next_durations[r]);
    end
    // A write past the last register must leave every duration alone.
    cfg_index <= CFG_IDX_W'(NUM_REGS + $urandom_range(0, 7));
    cfg_data  <= $urandom;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    logic [7:0] directed [$];
    int pick;
    in_valid      <= 1'b0;
    button_levels <= '0;
    out_ready     <= 1'b0;
    cfg_write     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    rx_mode       <= RX_FREE;
    rx_phase      <= '0;
    sb = new();
    burst_left     = 0;
    sender_no_gaps = 1'b0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      chan_level[ch]    = 1'b1;
      chan_run_left[ch] = $urandom_range(98, 110);
    end
    rst <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    directed = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hAA, 8'h55};
    for (int ch = 0; ch < CHANNELS; ch++) directed.push_back(~(8'h01 << ch));
    directed.push_back(8'hFF);
    directed.push_back(8'h0F);
    directed.push_back(8'hF0);
    directed.push_back(8'h00);
    foreach (directed[k]) send_tick(directed[k]);
    run_random(100);
    finish_phase();

    for (int phase = 1; phase <= 4; phase++) begin
      if (phase == 1) begin
        next_durations = '{32'd0, 32'd1, TOGGLE_ONLY, TOGGLE_ONLY - 32'd1,
                           32'd0, 32'd2, 32'h8000_0000, 32'd100};
      end else begin
        for (int r = 0; r < NUM_REGS; r++) begin
          pick = $urandom_range(0, 9);
          if (pick == 0)      next_durations[r] = TOGGLE_ONLY;
          else if (pick == 1) next_durations[r] = '0;
          else if (pick == 2) next_durations[r] = $urandom;
          else                next_durations[r] = $urandom_range(1, 200);
        end
      end
      program_durations();
      sender_no_gaps = (phase == 2);
      run_random(125);
      finish_phase();
    end

    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
